[src/hpr_pkg.sv]
// types, constants and reciprocal factors shared by the hsv to rgb duty pipeline
package hpr_pkg;

	localparam int HUE_W = 9;
	localparam int PCT_W = 7;
	localparam int DUTY_W = 14;
	localparam int FRAC_W = 6;
	localparam int SQ_W = 14;
	localparam int NUM_W = 20;

	localparam int DUTY_SCALE_DEF = 8192;

	localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
	localparam logic [SQ_W-1:0] PCT_SQ = 14'd10000;

	// f = floor(5*hr/3) as a multiply and shift, exact for hr below 60
	localparam logic [9:0] FRAC_MUL = 10'd855;
	localparam int FRAC_SHIFT = 9;

	// floor(x/100) for x below 2^14
	localparam logic [14:0] P_MUL = 15'd20972;
	localparam int P_SHIFT = 21;

	// floor(x/10000) for x below 2^20
	localparam logic [20:0] QT_MUL = 21'd1717987;
	localparam int QT_SHIFT = 34;

	typedef logic [2:0] sector_t;
	localparam sector_t SEC_RY = 3'd0;
	localparam sector_t SEC_YG = 3'd1;
	localparam sector_t SEC_GC = 3'd2;
	localparam sector_t SEC_CB = 3'd3;
	localparam sector_t SEC_BM = 3'd4;
	localparam sector_t SEC_MR = 3'd5;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] saturation;
		logic [PCT_W-1:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [DUTY_W-1:0] red_duty;
		logic [DUTY_W-1:0] green_duty;
		logic [DUTY_W-1:0] blue_duty;
		logic              ok;
	} rgb_duty_t;

	typedef struct packed {
		logic              ok;
		sector_t           sector;
		logic [PCT_W-1:0]  f;
		logic [PCT_W-1:0]  s;
		logic [PCT_W-1:0]  v;
		logic [SQ_W-1:0]   pv;
	} front_t;

	typedef struct packed {
		logic              ok;
		sector_t           sector;
		logic [PCT_W-1:0]  v;
		logic [PCT_W-1:0]  p;
		logic [PCT_W-1:0]  q;
		logic [PCT_W-1:0]  t;
	} level_t;

endpackage

[src/hpr_front.sv]
// range check, sector split, fraction and v*(100-s), first two pipeline stages
module hpr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  hpr_pkg::hsv_t  in_data,
	output logic           valid_s2,
	output hpr_pkg::front_t data_s2
);

	logic                          ok_c;
	logic [hpr_pkg::HUE_W-1:0]     h_c;
	hpr_pkg::sector_t              sector_c;
	logic [hpr_pkg::HUE_W-1:0]     base_c;
	logic [hpr_pkg::HUE_W-1:0]     hr_full_c;

	logic                          valid_s1;
	logic                          ok_s1;
	hpr_pkg::sector_t              sector_s1;
	logic [hpr_pkg::FRAC_W-1:0]    hr_s1;
	logic [hpr_pkg::PCT_W-1:0]     s_s1;
	logic [hpr_pkg::PCT_W-1:0]     v_s1;

	logic [15:0]                   fprod_c;
	logic [hpr_pkg::PCT_W-1:0]     sinv_c;

	always_comb begin
		ok_c = (in_data.hue <= hpr_pkg::HUE_MAX) && (in_data.saturation <= hpr_pkg::PCT_MAX)
			&& (in_data.brightness <= hpr_pkg::PCT_MAX);
		h_c = (in_data.hue == hpr_pkg::HUE_MAX) ? '0 : in_data.hue;
		if (h_c < 9'd60) begin
			sector_c = hpr_pkg::SEC_RY;
		end else if (h_c < 9'd120) begin
			sector_c = hpr_pkg::SEC_YG;
		end else if (h_c < 9'd180) begin
			sector_c = hpr_pkg::SEC_GC;
		end else if (h_c < 9'd240) begin
			sector_c = hpr_pkg::SEC_CB;
		end else if (h_c < 9'd300) begin
			sector_c = hpr_pkg::SEC_BM;
		end else begin
			sector_c = hpr_pkg::SEC_MR;
		end
		case (sector_c)
			hpr_pkg::SEC_RY: base_c = 9'd0;
			hpr_pkg::SEC_YG: base_c = 9'd60;
			hpr_pkg::SEC_GC: base_c = 9'd120;
			hpr_pkg::SEC_CB: base_c = 9'd180;
			hpr_pkg::SEC_BM: base_c = 9'd240;
			default:         base_c = 9'd300;
		endcase
		hr_full_c = h_c - base_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1     <= ok_c;
			sector_s1 <= sector_c;
			hr_s1     <= hr_full_c[hpr_pkg::FRAC_W-1:0];
			s_s1      <= in_data.saturation;
			v_s1      <= in_data.brightness;
		end
	end

	assign fprod_c = 16'(hr_s1) * 16'(hpr_pkg::FRAC_MUL);
	assign sinv_c  = hpr_pkg::PCT_MAX - s_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2.ok     <= ok_s1;
			data_s2.sector <= sector_s1;
			data_s2.f      <= fprod_c[hpr_pkg::FRAC_SHIFT +: hpr_pkg::PCT_W];
			data_s2.s      <= s_s1;
			data_s2.v      <= v_s1;
			data_s2.pv     <= hpr_pkg::SQ_W'(v_s1) * hpr_pkg::SQ_W'(sinv_c);
		end
	end

endmodule

[src/hpr_level.sv]
// p, q and t levels in percent, stages three to five
module hpr_level (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            valid_s2,
	input  hpr_pkg::front_t data_s2,
	output logic            valid_s5,
	output hpr_pkg::level_t data_s5
);

	logic                         valid_s3;
	logic                         valid_s4;
	logic                         ok_s3;
	logic                         ok_s4;
	hpr_pkg::sector_t             sector_s3;
	hpr_pkg::sector_t             sector_s4;
	logic [hpr_pkg::PCT_W-1:0]    v_s3;
	logic [hpr_pkg::PCT_W-1:0]    v_s4;
	logic [hpr_pkg::PCT_W-1:0]    p_s3;
	logic [hpr_pkg::PCT_W-1:0]    p_s4;
	logic [hpr_pkg::SQ_W-1:0]     fs_s3;
	logic [hpr_pkg::SQ_W-1:0]     gs_s3;
	logic [hpr_pkg::NUM_W-1:0]    qn_s4;
	logic [hpr_pkg::NUM_W-1:0]    tn_s4;

	logic [28:0]                  pprod_c;
	logic [hpr_pkg::PCT_W-1:0]    finv_c;
	logic [hpr_pkg::SQ_W-1:0]     qd_c;
	logic [hpr_pkg::SQ_W-1:0]     td_c;
	logic [40:0]                  qprod_c;
	logic [40:0]                  tprod_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage 3: f*s, s*(100-f), p = pv/100
	assign pprod_c = 29'(data_s2.pv) * 29'(hpr_pkg::P_MUL);
	assign finv_c  = hpr_pkg::PCT_MAX - data_s2.f;

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s3     <= data_s2.ok;
			sector_s3 <= data_s2.sector;
			v_s3      <= data_s2.v;
			p_s3      <= pprod_c[hpr_pkg::P_SHIFT +: hpr_pkg::PCT_W];
			fs_s3     <= hpr_pkg::SQ_W'(data_s2.f) * hpr_pkg::SQ_W'(data_s2.s);
			gs_s3     <= hpr_pkg::SQ_W'(data_s2.s) * hpr_pkg::SQ_W'(finv_c);
		end
	end

	// stage 4: numerators of q and t
	assign qd_c = hpr_pkg::PCT_SQ - fs_s3;
	assign td_c = hpr_pkg::PCT_SQ - gs_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s4     <= ok_s3;
			sector_s4 <= sector_s3;
			v_s4      <= v_s3;
			p_s4      <= p_s3;
			qn_s4     <= hpr_pkg::NUM_W'(v_s3) * hpr_pkg::NUM_W'(qd_c);
			tn_s4     <= hpr_pkg::NUM_W'(v_s3) * hpr_pkg::NUM_W'(td_c);
		end
	end

	// stage 5: divide by 10000
	assign qprod_c = 41'(qn_s4) * 41'(hpr_pkg::QT_MUL);
	assign tprod_c = 41'(tn_s4) * 41'(hpr_pkg::QT_MUL);

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s5.ok     <= ok_s4;
			data_s5.sector <= sector_s4;
			data_s5.v      <= v_s4;
			data_s5.p      <= p_s4;
			data_s5.q      <= qprod_c[hpr_pkg::QT_SHIFT +: hpr_pkg::PCT_W];
			data_s5.t      <= tprod_c[hpr_pkg::QT_SHIFT +: hpr_pkg::PCT_W];
		end
	end

endmodule

[src/hpr_duty.sv]
// sector color pick and percent to duty scaling, stages six and seven
module hpr_duty #(
	parameter int DUTY_SCALE = hpr_pkg::DUTY_SCALE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_s5,
	input  hpr_pkg::level_t    data_s5,
	output logic               valid_s7,
	output hpr_pkg::rgb_duty_t data_s7
);

	localparam int PW = $clog2(100 * DUTY_SCALE + 1);
	localparam int K = PW + 7;
	localparam int RW = K + hpr_pkg::DUTY_W;
	localparam longint unsigned RECIP = ((64'd1 << K) + 64'd99) / 64'd100;

	logic [hpr_pkg::PCT_W-1:0] r_c;
	logic [hpr_pkg::PCT_W-1:0] g_c;
	logic [hpr_pkg::PCT_W-1:0] b_c;

	logic          valid_s6;
	logic          ok_s6;
	logic [PW-1:0] rx_s6;
	logic [PW-1:0] gx_s6;
	logic [PW-1:0] bx_s6;

	logic [RW-1:0] rq_c;
	logic [RW-1:0] gq_c;
	logic [RW-1:0] bq_c;

	always_comb begin
		case (data_s5.sector)
			hpr_pkg::SEC_RY: begin
				r_c = data_s5.v; g_c = data_s5.t; b_c = data_s5.p;
			end
			hpr_pkg::SEC_YG: begin
				r_c = data_s5.q; g_c = data_s5.v; b_c = data_s5.p;
			end
			hpr_pkg::SEC_GC: begin
				r_c = data_s5.p; g_c = data_s5.v; b_c = data_s5.t;
			end
			hpr_pkg::SEC_CB: begin
				r_c = data_s5.p; g_c = data_s5.q; b_c = data_s5.v;
			end
			hpr_pkg::SEC_BM: begin
				r_c = data_s5.t; g_c = data_s5.p; b_c = data_s5.v;
			end
			default: begin
				r_c = data_s5.v; g_c = data_s5.p; b_c = data_s5.q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s6 <= data_s5.ok;
			rx_s6 <= PW'(r_c) * PW'(DUTY_SCALE);
			gx_s6 <= PW'(g_c) * PW'(DUTY_SCALE);
			bx_s6 <= PW'(b_c) * PW'(DUTY_SCALE);
		end
	end

	// divide by 100 through the reciprocal, low duty bits kept
	assign rq_c = RW'(rx_s6) * RW'(RECIP);
	assign gq_c = RW'(gx_s6) * RW'(RECIP);
	assign bq_c = RW'(bx_s6) * RW'(RECIP);

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s7.ok         <= ok_s6;
			data_s7.red_duty   <= ok_s6 ? rq_c[K +: hpr_pkg::DUTY_W] : '0;
			data_s7.green_duty <= ok_s6 ? gq_c[K +: hpr_pkg::DUTY_W] : '0;
			data_s7.blue_duty  <= ok_s6 ? bq_c[K +: hpr_pkg::DUTY_W] : '0;
		end
	end

endmodule

[src/hsv_percent_to_rgb_duty.sv]
// top level of the hsv percent to rgb pwm duty converter
// Converts hue (degrees) with saturation and value (percent) into three PWM duties, one
// item per clock cycle while out_ready is high, through a seven-stage pipeline. The whole
// pipeline advances together: it moves whenever the output register is empty or its item
// is being taken, so in_ready follows out_ready while the output holds an item. Items with
// hue above 360 or saturation or value above 100 come out with ok low and all duties zero;
// hue 360 equals hue 0. Each duty is pct*DUTY_SCALE/100 truncated, keeping the low 14 bits.
module hsv_percent_to_rgb_duty #(
	parameter int DUTY_SCALE = hpr_pkg::DUTY_SCALE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hpr_pkg::hsv_t      in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output hpr_pkg::rgb_duty_t out_data
);

	logic            adv;
	logic            valid_s2;
	logic            valid_s5;
	hpr_pkg::front_t data_s2;
	hpr_pkg::level_t data_s5;

	// the pipeline moves when the last stage is empty or drains this cycle
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	hpr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_data  (in_data),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	hpr_level u_level (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s5 (valid_s5),
		.data_s5  (data_s5)
	);

	hpr_duty #(
		.DUTY_SCALE (DUTY_SCALE)
	) u_duty (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s5 (valid_s5),
		.data_s5  (data_s5),
		.valid_s7 (out_valid),
		.data_s7  (out_data)
	);

endmodule
